/* hw/rtl/plist_pkg.sv */
// Shared types and codes for the positional list engine.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package plist_pkg;

  localparam int unsigned CmdW      = 3;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned PosW      = 7;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned CapacityDef  = 16;
  localparam int unsigned DataWidthDef = 32;

  // Command codes
  localparam logic [CmdW-1:0] CMD_INS_AT    = 3'd0;
  localparam logic [CmdW-1:0] CMD_INS_FRONT = 3'd1;
  localparam logic [CmdW-1:0] CMD_INS_BACK  = 3'd2;
  localparam logic [CmdW-1:0] CMD_REM_AT    = 3'd3;
  localparam logic [CmdW-1:0] CMD_REM_FRONT = 3'd4;
  localparam logic [CmdW-1:0] CMD_REM_BACK  = 3'd5;
  localparam logic [CmdW-1:0] CMD_FIND      = 3'd6;
  localparam logic [CmdW-1:0] CMD_READ_AT   = 3'd7;

  // Result status codes
  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_RANGE     = 3'd1;
  localparam logic [StatusW-1:0] ST_EMPTY     = 3'd2;
  localparam logic [StatusW-1:0] ST_FULL      = 3'd3;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd4;

  // Broadcast control from the command decoder to every cell
  typedef struct packed {
    logic            ins_en;
    logic            rem_en;
    logic [PosW-1:0] pos;
    logic [PosW-1:0] count;
  } plist_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/plist_cell.sv */
// One storage cell of the list chain: holds one entry, shifts with its neighbors.
// Depends on plist_pkg for the broadcast control struct.
`default_nettype none

module plist_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned DATA_WIDTH = plist_pkg::DataWidthDef
) (
  input  wire                           clk_i,
  input  wire plist_pkg::plist_ctrl_t   ctrl_i,
  input  wire logic signed [DATA_WIDTH-1:0] value_i,
  input  wire logic signed [DATA_WIDTH-1:0] left_i,
  input  wire logic signed [DATA_WIDTH-1:0] right_i,
  output logic signed [DATA_WIDTH-1:0]  data_o,
  output logic                          match_o
);
  import plist_pkg::*;

  localparam logic [PosW-1:0] IdxC = PosW'(IDX);

  logic signed [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins_en) begin
      // open a gap at pos: cells above take their lower neighbor
      if (IdxC > ctrl_i.pos) begin
        data_d = left_i;
      end else if (IdxC == ctrl_i.pos) begin
        data_d = value_i;
      end
    end else if (ctrl_i.rem_en && (IdxC >= ctrl_i.pos)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  // only live entries may match
  assign match_o = (IdxC < ctrl_i.count) && (data_q == value_i);

endmodule

`default_nettype wire

/* hw/rtl/plist_find.sv */
// Priority encoder: lowest matching cell index for the find command.
// Depends on plist_pkg for the position width.
`default_nettype none

module plist_find #(
  parameter int unsigned CAPACITY = plist_pkg::CapacityDef
) (
  input  wire logic [CAPACITY-1:0]    match_i,
  output logic                        hit_o,
  output logic [plist_pkg::PosW-1:0]  index_o
);
  import plist_pkg::*;

  always_comb begin
    index_o = '0;
    // scan downward so the lowest set bit wins
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_i[i]) begin
        index_o = PosW'(i);
      end
    end
  end

  assign hit_o = |match_i;

endmodule

`default_nettype wire

/* hw/rtl/positional_list_engine_unit.sv */
// Top level of the positional list engine: decoder, cell chain, find encoder, result regs.
// Depends on plist_pkg, plist_cell and plist_find.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------------
//  command   | start / busy       | cmd_i, value_i, position_i
//  result    | out_valid_o strobe | data_out_o, found_index_o, status_o,
//            |                    | length_o, is_empty_o
//
// One command is taken per clock cycle while not busy; its result passes the first stage
// registers (cell compare and read mux) and the find priority encoder before it strobes.
// The cell chain updates at the transfer edge, so back-to-back commands see it.
// busy stays high for the first cycle after reset release, then low.
// The result is shown for one cycle only; the receiver cannot stall it.
`default_nettype none

module positional_list_engine_unit #(
  parameter int unsigned CAPACITY   = plist_pkg::CapacityDef,
  parameter int unsigned DATA_WIDTH = plist_pkg::DataWidthDef
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start,
  output logic                                 busy,
  input  wire logic [plist_pkg::CmdW-1:0]      cmd_i,
  input  wire logic signed [plist_pkg::ValueW-1:0] value_i,
  input  wire logic [plist_pkg::PosW-1:0]      position_i,
  output logic                                 out_valid_o,
  output logic signed [plist_pkg::ValueW-1:0]  data_out_o,
  output logic [plist_pkg::PosW-1:0]           found_index_o,
  output logic [plist_pkg::StatusW-1:0]        status_o,
  output logic [plist_pkg::PosW-1:0]           length_o,
  output logic                                 is_empty_o
);
  import plist_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam logic [PosW-1:0] CapC = PosW'(CAPACITY);

  logic                         busy_q;
  logic                         accept;
  logic [CntW-1:0]              count_q, count_d;
  logic [PosW-1:0]              cnt7;
  logic [PosW-1:0]              eff_pos;
  logic signed [DATA_WIDTH-1:0] v;
  logic signed [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]          match;
  logic signed [DATA_WIDTH-1:0] sel_data;
  plist_ctrl_t                  ctrl;
  logic [StatusW-1:0]           status_d;
  logic signed [ValueW-1:0]     data_d;
  logic                         is_find;

  // first stage registers
  logic                         s1_vld_q;
  logic                         s1_find_q;
  logic [StatusW-1:0]           s1_status_q;
  logic signed [ValueW-1:0]     s1_data_q;
  logic [CAPACITY-1:0]          s1_match_q;
  logic [PosW-1:0]              s1_len_q;

  logic                         find_hit;
  logic [PosW-1:0]              find_idx;

  // result registers
  logic                         out_vld_q;
  logic signed [ValueW-1:0]     out_data_q;
  logic [PosW-1:0]              out_found_q;
  logic [StatusW-1:0]           out_status_q;
  logic [PosW-1:0]              out_len_q;

  assign busy   = busy_q;
  assign accept = start && !busy_q;
  assign cnt7   = PosW'(count_q);
  assign v      = DATA_WIDTH'(value_i);
  assign sel_data = cell_data[eff_pos[IdxW-1:0]];

  always_comb begin
    unique case (cmd_i)
      CMD_INS_FRONT, CMD_REM_FRONT: eff_pos = '0;
      CMD_INS_BACK:                 eff_pos = cnt7;
      CMD_REM_BACK:                 eff_pos = (cnt7 == '0) ? '0 : cnt7 - PosW'(1);
      default:                      eff_pos = position_i;
    endcase
  end

  always_comb begin
    ctrl.ins_en = 1'b0;
    ctrl.rem_en = 1'b0;
    ctrl.pos    = eff_pos;
    ctrl.count  = cnt7;
    status_d    = ST_OK;
    data_d      = '0;
    is_find     = 1'b0;
    count_d     = count_q;
    unique case (cmd_i)
      CMD_INS_AT, CMD_INS_FRONT, CMD_INS_BACK: begin
        if (eff_pos > cnt7) begin
          status_d = ST_RANGE;
        end else if (cnt7 >= CapC) begin
          status_d = ST_FULL;
        end else begin
          ctrl.ins_en = accept;
          count_d     = count_q + CntW'(1);
        end
      end
      CMD_REM_AT, CMD_REM_FRONT, CMD_REM_BACK, CMD_READ_AT: begin
        if (cnt7 == '0) begin
          status_d = ST_EMPTY;
        end else if (eff_pos >= cnt7) begin
          status_d = ST_RANGE;
        end else begin
          data_d = ValueW'(sel_data);
          if (cmd_i != CMD_READ_AT) begin
            ctrl.rem_en = accept;
            count_d     = count_q - CntW'(1);
          end
        end
      end
      default: begin
        status_d = ST_NOT_FOUND;
        is_find  = 1'b1;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = v;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    plist_cell #(
      .IDX        (i),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .value_i (v),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .match_o (match[i])
    );
  end

  plist_find #(
    .CAPACITY (CAPACITY)
  ) u_find (
    .match_i (s1_match_q),
    .hit_o   (find_hit),
    .index_o (find_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      count_q   <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q    <= 1'b0;
      s1_vld_q  <= accept;
      out_vld_q <= s1_vld_q;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_find_q   <= is_find;
      s1_status_q <= status_d;
      s1_data_q   <= data_d;
      s1_match_q  <= match;
      s1_len_q    <= PosW'(count_d);
    end
    if (s1_vld_q) begin
      out_data_q <= s1_data_q;
      out_len_q  <= s1_len_q;
      if (s1_find_q && find_hit) begin
        out_found_q  <= find_idx;
        out_status_q <= ST_OK;
      end else begin
        out_found_q  <= '0;
        out_status_q <= s1_status_q;
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign data_out_o    = out_data_q;
  assign found_index_o = out_found_q;
  assign status_o      = out_status_q;
  assign length_o      = out_len_q;
  assign is_empty_o    = (out_len_q == '0);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 out_valid_o)
    else $error("result strobe missing two cycles after transfer");

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (length_o <= CapC))
    else $error("length exceeds capacity");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (data_out_o == '0) && (found_index_o == '0))
    else $error("error result carries data");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(accept) |-> $stable(count_q))
    else $error("list length changed without a transfer");

endmodule

`default_nettype wire
